[hdl/aavr_pkg.sv]
package aavr_pkg;

  // Default configuration of the block.
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Fixed field widths.
  localparam int AXIS_W = 16;
  localparam int TOL_W  = 21;
  localparam logic [TOL_W-1:0] TOL_RESET = 21'd16;

  // CORDIC datapath: Q2.30 values held with headroom, angle in 2^-32 turn.
  localparam int CX_W        = 34;
  localparam int CORDIC_TABN = 24;
  localparam logic signed [CX_W-1:0] GAIN_Q30 = 34'sd652032874;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } aavr_qstat_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic signed [CX_W-1:0] atan_turn(input int i);
    logic signed [CX_W-1:0] r;
    r = '0;
    unique case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933405;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335086;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41721;
      15: r = 34'sd20860;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2607;
      19: r = 34'sd1303;
      20: r = 34'sd651;
      21: r = 34'sd325;
      22: r = 34'sd162;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/aavr_if.sv]
interface aavr_in_if import aavr_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int AW = ANGLE_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic signed [CW-1:0]     vec_x;
  logic signed [CW-1:0]     vec_y;
  logic signed [CW-1:0]     vec_z;
  logic signed [AXIS_W-1:0] axis_x;
  logic signed [AXIS_W-1:0] axis_y;
  logic signed [AXIS_W-1:0] axis_z;
  logic [AW-1:0]            angle;

  modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                output ready);
endinterface

interface aavr_out_if import aavr_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] rot_x;
  logic signed [CW-1:0] rot_y;
  logic signed [CW-1:0] rot_z;
  logic                 axis_error;

  modport source (output valid, rot_x, rot_y, rot_z, axis_error, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, axis_error, output ready);
endinterface

interface aavr_cfg_if import aavr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] norm_tolerance;

  modport source (output valid, norm_tolerance, input ready);
  modport sink (input valid, norm_tolerance, output ready);
endinterface

[hdl/aavr_front.sv]
module aavr_front import aavr_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int AW = ANGLE_WIDTH_DEF,
  localparam int PW = 3 * CW + 3 * AXIS_W + AW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [TOL_W-1:0] tol_i,
  aavr_in_if.sink          in_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [PW-1:0]    data_o
);

  localparam int SQ_W = 2 * AXIS_W;
  localparam int N_W  = SQ_W + 2;

  logic                   vld_q;
  logic [PW-1:0]          data_q;
  logic signed [SQ_W-1:0] sq_x, sq_y, sq_z;
  logic signed [N_W-1:0]  norm, excess, tol_ext;
  logic                   err;

  // Squared norm in Q2.28, compared with one plus the tolerance.
  always_comb begin
    sq_x    = in_i.axis_x * in_i.axis_x;
    sq_y    = in_i.axis_y * in_i.axis_y;
    sq_z    = in_i.axis_z * in_i.axis_z;
    norm    = N_W'(sq_x) + N_W'(sq_y) + N_W'(sq_z);
    excess  = norm - (N_W'(1) << 28);
    tol_ext = {{(N_W - TOL_W){1'b0}}, tol_i};
    err     = excess > tol_ext;
  end

  assign in_i.ready = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= {err, in_i.angle, in_i.axis_z, in_i.axis_y, in_i.axis_x,
                 in_i.vec_z, in_i.vec_y, in_i.vec_x};
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule

[hdl/aavr_queue.sv]
module aavr_queue import aavr_pkg::*; #(
  parameter int W = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [W-1:0] out_data_o,
  output aavr_qstat_t stat_o
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [W-1:0]     mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign stat_o.full  = cnt_q == CNT_W'(Q_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign in_ready_o   = !stat_o.full;
  assign out_valid_o  = !stat_o.empty;
  assign push         = in_valid_i && in_ready_o;
  assign pop          = out_valid_o && out_ready_i;
  assign out_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

endmodule

[hdl/aavr_back.sv]
module aavr_back import aavr_pkg::*; #(
  parameter int CW    = COORD_WIDTH_DEF,
  parameter int AW    = ANGLE_WIDTH_DEF,
  parameter int STEPS = CORDIC_STEPS_DEF,
  localparam int PW   = 3 * CW + 3 * AXIS_W + AW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [PW-1:0] in_data_i,
  aavr_out_if.source    out_o
);

  localparam int NST   = STEPS + 5;
  localparam int OMC_W = CX_W + 1;
  localparam int AA_W  = 2 * AXIS_W;
  localparam int OA_W  = OMC_W + AA_W;
  localparam int SA_W  = CX_W + AXIS_W;
  localparam int EW    = OA_W + 2;
  // Entries of an accepted axis stay well below 8 in magnitude, so Q28 fits in 32 bits.
  localparam int MW    = 32;
  localparam int PRW   = MW + CW;
  localparam int RSW   = PRW + 2;
  localparam int RW    = RSW - 28;
  localparam int A_LO  = 3 * CW;
  localparam int ANG_LO = 3 * CW + 3 * AXIS_W;
  localparam logic signed [EW-1:0]  HALF_E = EW'(1) << 29;
  localparam logic signed [RSW-1:0] HALF_P = RSW'(1) << 27;

  logic                  adv;
  logic                  vld_q [NST];
  logic [PW-1:0]         pay_q [NST];
  logic signed [CX_W-1:0] x_q [STEPS+1];
  logic signed [CX_W-1:0] y_q [STEPS+1];
  logic signed [CX_W-1:0] z_q [STEPS+1];
  logic                  neg_q [STEPS+1];

  logic signed [CX_W-1:0]  c_q, s_q;
  logic signed [OMC_W-1:0] omc_q;
  logic signed [AA_W-1:0]  aa_q [6];
  logic signed [OA_W-1:0]  oaa_q [6];
  logic signed [EW-1:0]    c28_q;
  logic signed [SA_W-1:0]  sa_q [3];
  logic signed [MW-1:0]    m_q [9];
  logic signed [PRW-1:0]   pr_q [9];
  logic                    out_vld_q;
  logic signed [CW-1:0]    rot_q [3];
  logic                    err_q;

  // Stage 0: fold the angle into [-1/4, 1/4) turn.
  logic [31:0]            turn;
  logic                   in_neg;
  logic signed [CX_W-1:0] z_init;

  always_comb begin
    turn        = {in_data_i[ANG_LO +: AW], {(32 - AW){1'b0}}};
    in_neg      = turn[31] ^ turn[30];
    turn[31]    = turn[31] ^ in_neg;
    z_init      = CX_W'($signed(turn));
  end

  assign adv        = !out_vld_q || out_o.ready;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[NST-1];
    end
  end

  // Operand helpers for the matrix stages.
  logic signed [AXIS_W-1:0] a1 [3];
  logic signed [AXIS_W-1:0] a2 [3];
  logic signed [CW-1:0]     v3 [3];
  logic signed [CW-1:0]     v4 [3];
  logic signed [CX_W-1:0]   c_d, s_d;
  logic signed [EW-1:0]     o_e [6];
  logic signed [EW-1:0]     s_e [3];
  logic signed [EW-1:0]     e_d [9];
  logic signed [EW-1:0]     e_r [9];
  logic signed [RSW-1:0]    rs [3];
  logic signed [RW-1:0]     rq [3];
  logic signed [CW-1:0]     sat [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a1[k] = $signed(pay_q[STEPS][A_LO + k * AXIS_W +: AXIS_W]);
      a2[k] = $signed(pay_q[STEPS+1][A_LO + k * AXIS_W +: AXIS_W]);
      v3[k] = $signed(pay_q[STEPS+3][k * CW +: CW]);
      v4[k] = $signed(pay_q[STEPS+4][k * CW +: CW]);
    end
    c_d = neg_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
    s_d = neg_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];
    for (int k = 0; k < 6; k++) begin
      o_e[k] = EW'(oaa_q[k]);
    end
    for (int k = 0; k < 3; k++) begin
      s_e[k] = {{(EW - SA_W - 14){sa_q[k][SA_W-1]}}, sa_q[k], 14'b0};
    end
    // Entries in Q58: (1-c)*a*a^T + c*I + s*[a]x.
    e_d[0] = o_e[0] + c28_q;
    e_d[4] = o_e[1] + c28_q;
    e_d[8] = o_e[2] + c28_q;
    e_d[1] = o_e[3] - s_e[2];
    e_d[3] = o_e[3] + s_e[2];
    e_d[2] = o_e[4] + s_e[1];
    e_d[6] = o_e[4] - s_e[1];
    e_d[5] = o_e[5] - s_e[0];
    e_d[7] = o_e[5] + s_e[0];
    for (int k = 0; k < 9; k++) begin
      e_r[k] = (e_d[k] + HALF_E) >>> 30;
    end
    for (int r = 0; r < 3; r++) begin
      rs[r] = RSW'(pr_q[3*r]) + RSW'(pr_q[3*r+1]) + RSW'(pr_q[3*r+2]) + HALF_P;
      rq[r] = rs[r][RSW-1:28];
      if ((&rq[r][RW-1:CW-1]) || !(|rq[r][RW-1:CW-1])) begin
        sat[r] = rq[r][CW-1:0];
      end else if (rq[r][RW-1]) begin
        sat[r] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        sat[r] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pay_q[0] <= in_data_i;
      for (int k = 1; k < NST; k++) begin
        pay_q[k] <= pay_q[k-1];
      end
      x_q[0]   <= GAIN_Q30;
      y_q[0]   <= '0;
      z_q[0]   <= z_init;
      neg_q[0] <= in_neg;
      // One CORDIC iteration per stage, each with its own fixed shift.
      for (int i = 0; i < STEPS; i++) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][CX_W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_turn(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_turn(i);
        end
      end
      c_q   <= c_d;
      s_q   <= s_d;
      omc_q <= (OMC_W'(1) <<< 30) - OMC_W'(c_d);
      aa_q[0] <= a1[0] * a1[0];
      aa_q[1] <= a1[1] * a1[1];
      aa_q[2] <= a1[2] * a1[2];
      aa_q[3] <= a1[0] * a1[1];
      aa_q[4] <= a1[0] * a1[2];
      aa_q[5] <= a1[1] * a1[2];
      for (int k = 0; k < 6; k++) begin
        oaa_q[k] <= omc_q * aa_q[k];
      end
      c28_q <= {{(EW - CX_W - 28){c_q[CX_W-1]}}, c_q, 28'b0};
      for (int k = 0; k < 3; k++) begin
        sa_q[k] <= s_q * a2[k];
      end
      for (int k = 0; k < 9; k++) begin
        m_q[k] <= e_r[k][MW-1:0];
      end
      for (int k = 0; k < 9; k++) begin
        pr_q[k] <= m_q[k] * v3[k % 3];
      end
      err_q <= pay_q[STEPS+4][PW-1];
      for (int r = 0; r < 3; r++) begin
        rot_q[r] <= pay_q[STEPS+4][PW-1] ? v4[r] : sat[r];
      end
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.rot_x      = rot_q[0];
  assign out_o.rot_y      = rot_q[1];
  assign out_o.rot_z      = rot_q[2];
  assign out_o.axis_error = err_q;

endmodule

[hdl/axis_angle_vector_rotation_unit.sv]
// Axis-angle rotation of a fixed-point 3D vector.
//
// vec_in_i carries a vector (Q15.16 at the default width), a unit axis in
// Q1.14 and a binary angle; rot_out_o returns the rotated vector, saturated
// per component, with axis_error set when the squared axis norm exceeds one
// by more than the tolerance. In that case the vector is returned unchanged.
// cfg_i writes the tolerance (units of 2^-28); it is always ready.
//
// A transfer on vec_in_i passes through the norm-check register in the front,
// the queue, the angle-fold register, the CORDIC iteration stages, the matrix
// and product stages and the output register before it reaches rot_out_o. One
// item is taken every cycle while rot_out_o is not stalled.
//
// While rot_out_o is stalled the back pipeline holds; the two-entry queue and
// the front register keep taking items until they are full, then vec_in_i
// drops ready. Reset empties every stage and sets the tolerance to 16.
module axis_angle_vector_rotation_unit import aavr_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aavr_cfg_if.sink    cfg_i,
  aavr_in_if.sink     vec_in_i,
  aavr_out_if.source  rot_out_o
);

  localparam int PW = 3 * COORD_WIDTH + 3 * AXIS_W + ANGLE_WIDTH + 1;

  logic [TOL_W-1:0] tol_q;
  logic             f_valid, q_in_ready;
  logic [PW-1:0]    f_data;
  logic             q_valid, b_ready;
  logic [PW-1:0]    q_data;
  aavr_qstat_t      q_stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.norm_tolerance;
    end
  end

  aavr_front #(
    .CW (COORD_WIDTH),
    .AW (ANGLE_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tol_i   (tol_q),
    .in_i    (vec_in_i),
    .valid_o (f_valid),
    .ready_i (q_in_ready),
    .data_o  (f_data)
  );

  aavr_queue #(
    .W (PW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (q_in_ready),
    .in_data_i   (f_data),
    .out_valid_o (q_valid),
    .out_ready_i (b_ready),
    .out_data_o  (q_data),
    .stat_o      (q_stat)
  );

  aavr_back #(
    .CW    (COORD_WIDTH),
    .AW    (ANGLE_WIDTH),
    .STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_ready_o (b_ready),
    .in_data_i  (q_data),
    .out_o      (rot_out_o)
  );

  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_front_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && !q_in_ready) |-> q_stat.full)
    else $error("front stalled while the queue has room");

  a_back_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !b_ready |-> rot_out_o.valid)
    else $error("back pipeline stalled with no result waiting");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.ready) |=> tol_q == $past(cfg_i.norm_tolerance))
    else $error("tolerance register missed a write");

endmodule
